### rtl/tci_pkg.sv
// ----------------------------------------------------------------------------
// Tone curve interpolator package
// Shared widths, register map, pipeline payload types and configuration type.
// ----------------------------------------------------------------------------
package tci_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int MAX_POINTS   = 6;
    localparam int T_BITS       = 16;
    localparam int CNT_BITS     = 3;
    localparam int PT_IDX_BITS  = $clog2(MAX_POINTS);
    localparam int REG_COUNT    = 2 + MAX_POINTS;
    localparam int REG_IDX_BITS = $clog2(REG_COUNT);
    localparam int ADDR_BITS    = REG_IDX_BITS + 2;
    localparam int APB_BITS     = 32;
    localparam int TDATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;

    // Divider: quotient bits resolved in each pipeline stage.
    localparam int DIV_STEPS    = 2;
    localparam int DIV_STAGES   = T_BITS / DIV_STEPS;

    // Segment select, divider, two smoothstep stages, two blend stages.
    localparam int PIPE_DEPTH   = 1 + DIV_STAGES + 2 + 2;
    localparam int INFL_BITS    = $clog2(PIPE_DEPTH + 1);

    // Smoothstep weight constant 3.0 in Q2.T_BITS.
    localparam logic [T_BITS+1:0] SMOOTH_K = (T_BITS + 2)'(3) << T_BITS;

    localparam logic [REG_IDX_BITS-1:0] REG_POINT_COUNT = REG_IDX_BITS'(0);
    localparam logic [REG_IDX_BITS-1:0] REG_SMOOTH_MODE = REG_IDX_BITS'(1);
    localparam logic [REG_IDX_BITS-1:0] REG_POINT_BASE  = REG_IDX_BITS'(2);

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [T_BITS-1:0]      t_frac;

    typedef struct packed {
        t_sample x;
        t_sample y;
    } t_point;

    typedef struct packed {
        logic [CNT_BITS-1:0]         point_count;
        logic                        smooth;
        t_point [MAX_POINTS-1:0]     points;
    } t_cfg;

    // Item inside the divider: partial remainder, divisor, quotient so far.
    typedef struct packed {
        t_sample rem;
        t_sample den;
        t_frac   q;
        t_sample ly;
        t_sample ry;
    } t_div_item;

    typedef struct packed {
        t_frac   t;
        t_sample ly;
        t_sample ry;
    } t_blend_item;

    typedef struct packed {
        t_frac                   t;
        t_sample                 ly;
        logic signed [SAMPLE_BITS:0] diff;
    } t_mul_item;

endpackage

### rtl/tci_seg.sv
// ----------------------------------------------------------------------------
// Tone curve segment select
// Finds the curve segment of a sample and forms the divider operands.
// ----------------------------------------------------------------------------
module tci_seg import tci_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_sample   i_sample,
    output logic      o_valid,
    input  logic      i_ready,
    output t_div_item o_item
);

    logic [CNT_BITS-1:0]    act_n;
    logic [MAX_POINTS-1:0]  gt;
    logic                   found;
    logic [PT_IDX_BITS-1:0] first_idx;
    logic [PT_IDX_BITS-1:0] last_idx;
    t_point                 lp;
    t_point                 rp;
    t_div_item              n_item;
    t_div_item              r_item;
    logic                   r_valid;
    logic                   en;

    always_comb begin
        if (i_cfg.point_count < CNT_BITS'(2)) begin
            act_n = CNT_BITS'(2);
        end else if (i_cfg.point_count > CNT_BITS'(MAX_POINTS)) begin
            act_n = CNT_BITS'(MAX_POINTS);
        end else begin
            act_n = i_cfg.point_count;
        end
        last_idx = PT_IDX_BITS'(act_n - CNT_BITS'(1));
    end

    always_comb begin
        found     = 1'b0;
        first_idx = '0;
        for (int i = 0; i < MAX_POINTS; i++) begin
            gt[i] = (CNT_BITS'(i) < act_n) && (i_cfg.points[i].x > i_sample);
        end
        for (int i = 0; i < MAX_POINTS; i++) begin
            if (!found && gt[i]) begin
                found     = 1'b1;
                first_idx = PT_IDX_BITS'(i);
            end
        end
    end

    // Outside a segment both y values carry the answer and the fraction is zero.
    always_comb begin
        lp = i_cfg.points[PT_IDX_BITS'(first_idx - 1'b1)];
        rp = i_cfg.points[first_idx];
        n_item.q = '0;
        if (found && first_idx == '0) begin
            n_item.rem = '0;
            n_item.den = SAMPLE_BITS'(1);
            n_item.ly  = i_cfg.points[0].y;
            n_item.ry  = i_cfg.points[0].y;
        end else if (!found) begin
            n_item.rem = '0;
            n_item.den = SAMPLE_BITS'(1);
            n_item.ly  = i_cfg.points[last_idx].y;
            n_item.ry  = i_cfg.points[last_idx].y;
        end else begin
            n_item.rem = i_sample - lp.x;
            n_item.den = rp.x - lp.x;
            n_item.ly  = lp.y;
            n_item.ry  = rp.y;
        end
    end

    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

### rtl/tci_div.sv
// ----------------------------------------------------------------------------
// Tone curve fraction divider
// Pipelined restoring divider giving the segment fraction in Q0.16.
// ----------------------------------------------------------------------------
module tci_div import tci_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_div_item   i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_blend_item o_item
);

    // The remainder always stays below the divisor, so it fits the sample width.
    function automatic t_div_item div_step(input t_div_item x);
        t_div_item            y;
        logic [SAMPLE_BITS:0] r2;
        y = x;
        for (int j = 0; j < DIV_STEPS; j++) begin
            r2 = {y.rem, 1'b0};
            if (r2 >= {1'b0, y.den}) begin
                r2  = r2 - {1'b0, y.den};
                y.q = {y.q[T_BITS-2:0], 1'b1};
            end else begin
                y.q = {y.q[T_BITS-2:0], 1'b0};
            end
            y.rem = r2[SAMPLE_BITS-1:0];
        end
        return y;
    endfunction

    logic [DIV_STAGES-1:0] r_vld;
    t_div_item             r_item [DIV_STAGES];
    logic [DIV_STAGES:0]   rdy;

    assign rdy[DIV_STAGES] = i_ready;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic      in_vld;
        t_div_item in_item;
        logic      en;

        if (k == 0) begin : g_first
            assign in_vld  = i_valid;
            assign in_item = i_item;
        end else begin : g_next
            assign in_vld  = r_vld[k-1];
            assign in_item = r_item[k-1];
        end

        assign en     = !r_vld[k] || rdy[k+1];
        assign rdy[k] = en;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en) begin
                r_vld[k] <= in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en && in_vld) begin
                r_item[k] <= div_step(in_item);
            end
        end
    end

    assign o_ready   = rdy[0];
    assign o_valid   = r_vld[DIV_STAGES-1];
    assign o_item.t  = r_item[DIV_STAGES-1].q;
    assign o_item.ly = r_item[DIV_STAGES-1].ly;
    assign o_item.ry = r_item[DIV_STAGES-1].ry;

endmodule

### rtl/tci_smooth.sv
// ----------------------------------------------------------------------------
// Tone curve smoothstep
// Two multiply stages forming t*t*(3 - 2t), selected in smooth mode.
// ----------------------------------------------------------------------------
module tci_smooth import tci_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_smooth,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_blend_item i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_mul_item   o_item
);

    localparam int SQ_BITS   = 2 * T_BITS;
    localparam int W_BITS    = T_BITS + 2;
    localparam int PROD_BITS = SQ_BITS + W_BITS;

    logic                 r_vld1;
    logic                 r_vld2;
    t_mul_item            r_item1;
    logic [SQ_BITS-1:0]   r_sq;
    t_mul_item            r_item2;
    t_mul_item            n_item2;
    logic [W_BITS-1:0]    weight;
    logic [PROD_BITS-1:0] prod;
    logic                 en1;
    logic                 en2;

    assign en2     = !r_vld2 || i_ready;
    assign en1     = !r_vld1 || en2;
    assign o_ready = en1;
    assign o_valid = r_vld2;
    assign o_item  = r_item2;

    // The smoothstep value stays below one, so it lies in the top fraction bits.
    always_comb begin
        weight    = SMOOTH_K - {1'b0, r_item1.t, 1'b0};
        prod      = PROD_BITS'(r_sq) * PROD_BITS'(weight);
        n_item2   = r_item1;
        if (i_smooth) begin
            n_item2.t = prod[SQ_BITS+T_BITS-1:SQ_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (en1) begin
                r_vld1 <= i_valid;
            end
            if (en2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_item1.t    <= i_item.t;
            r_item1.ly   <= i_item.ly;
            r_item1.diff <= $signed({1'b0, i_item.ry}) - $signed({1'b0, i_item.ly});
            r_sq         <= SQ_BITS'(i_item.t) * SQ_BITS'(i_item.t);
        end
        if (en2 && r_vld1) begin
            r_item2 <= n_item2;
        end
    end

endmodule

### rtl/tci_blend.sv
// ----------------------------------------------------------------------------
// Tone curve blend
// Forms ly + floor((ry - ly) * t / 2^16), equal to the weighted y blend.
// ----------------------------------------------------------------------------
module tci_blend import tci_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_mul_item i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_sample   o_height
);

    localparam int PROD_BITS = SAMPLE_BITS + T_BITS + 2;
    localparam int SUM_BITS  = SAMPLE_BITS + 2;

    logic                        r_vld1;
    logic                        r_vld2;
    logic signed [PROD_BITS-1:0] r_prod;
    t_sample                     r_ly;
    t_sample                     r_height;
    logic signed [SUM_BITS-1:0]  sum;
    logic                        en1;
    logic                        en2;

    assign en2      = !r_vld2 || i_ready;
    assign en1      = !r_vld1 || en2;
    assign o_ready  = en1;
    assign o_valid  = r_vld2;
    assign o_height = r_height;

    // The upper slice of the product is the floored quotient by 2^16.
    assign sum = $signed({2'b00, r_ly}) + $signed(r_prod[PROD_BITS-1:T_BITS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (en1) begin
                r_vld1 <= i_valid;
            end
            if (en2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_prod <= i_item.diff * $signed({1'b0, i_item.t});
            r_ly   <= i_item.ly;
        end
        if (en2 && r_vld1) begin
            r_height <= sum[SAMPLE_BITS-1:0];
        end
    end

endmodule

### rtl/tone_curve_interpolator.sv
// ----------------------------------------------------------------------------
// Tone curve interpolator
// Maps height samples through a piecewise linear or smoothstep tone curve.
// ----------------------------------------------------------------------------
// The block takes one sample request per clock while its output is not
// stalled, and returns one mapped height per sample, in order. In the
// pipeline, one stage selects the curve segment, eight stages of the
// restoring divider each resolve two bits of the Q0.16 segment fraction,
// two stages form the smoothstep product and two stages blend the y
// values, the last of which is the output register. Each
// stage holds its own valid bit and advances when it is empty or when the
// stage after it moves, so bubbles close up and a stalled output does not
// stop new requests until the pipeline is full. Software programs the curve
// through the register port while no request is in flight: point_count at
// byte 0x00, smooth_mode at 0x04 and point_0 to point_5 at 0x08 to 0x1C, with
// x in bits 31:16 and y in bits 15:0. Points must be sorted with distinct x,
// the first x zero and the last x full scale. After reset the curve is the
// identity line.
// ----------------------------------------------------------------------------
module tone_curve_interpolator import tci_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Register port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [APB_BITS-1:0]   pwdata,
    output logic [APB_BITS-1:0]   prdata,
    output logic                  pready,
    // Sample requests.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_BITS-1:0] s_axis_tdata,   // [15:0] sample
    // Mapped heights.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_BITS-1:0] m_axis_tdata    // [15:0] height
);

    logic [CNT_BITS-1:0]     r_point_count;
    logic                    r_smooth;
    t_point [MAX_POINTS-1:0] r_points;
    t_cfg                    cfg;

    logic [REG_IDX_BITS-1:0] reg_idx;
    logic [REG_IDX_BITS-1:0] pt_sel;
    logic                    pt_hit;
    logic                    wr_en;

    logic        seg_vld, seg_rdy;
    t_div_item   seg_item;
    logic        div_vld, div_rdy;
    t_blend_item div_item;
    logic        sm_vld, sm_rdy;
    t_mul_item   sm_item;
    t_sample     height;

    logic [INFL_BITS-1:0] r_inflight;
    logic [INFL_BITS-1:0] n_inflight;
    logic                 in_fire;
    logic                 out_fire;

    // ---------------------------------------------------------------- registers
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign pt_sel  = reg_idx - REG_POINT_BASE;
    assign pt_hit  = (reg_idx >= REG_POINT_BASE) && (pt_sel < REG_IDX_BITS'(MAX_POINTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= CNT_BITS'(2);
            r_smooth      <= 1'b0;
            // Point 1 starts at full scale, so the reset curve is the identity line.
            for (int i = 0; i < MAX_POINTS; i++) begin
                r_points[i] <= (i == 1) ? '1 : '0;
            end
        end else if (wr_en) begin
            priority if (reg_idx == REG_POINT_COUNT) begin
                r_point_count <= pwdata[CNT_BITS-1:0];
            end else if (reg_idx == REG_SMOOTH_MODE) begin
                r_smooth <= pwdata[0];
            end else if (pt_hit) begin
                r_points[pt_sel[PT_IDX_BITS-1:0]] <= pwdata[2*SAMPLE_BITS-1:0];
            end else begin
                r_smooth <= r_smooth;
            end
        end
    end

    always_comb begin
        priority if (reg_idx == REG_POINT_COUNT) begin
            prdata = APB_BITS'(r_point_count);
        end else if (reg_idx == REG_SMOOTH_MODE) begin
            prdata = APB_BITS'(r_smooth);
        end else if (pt_hit) begin
            prdata = APB_BITS'(r_points[pt_sel[PT_IDX_BITS-1:0]]);
        end else begin
            prdata = '0;
        end
    end

    assign cfg.point_count = r_point_count;
    assign cfg.smooth      = r_smooth;
    assign cfg.points      = r_points;

    // ----------------------------------------------------------------- pipeline
    tci_seg u_seg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_valid  (seg_vld),
        .i_ready  (seg_rdy),
        .o_item   (seg_item)
    );

    tci_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (seg_vld),
        .o_ready (seg_rdy),
        .i_item  (seg_item),
        .o_valid (div_vld),
        .i_ready (div_rdy),
        .o_item  (div_item)
    );

    tci_smooth u_smooth (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_smooth (r_smooth),
        .i_valid  (div_vld),
        .o_ready  (div_rdy),
        .i_item   (div_item),
        .o_valid  (sm_vld),
        .i_ready  (sm_rdy),
        .o_item   (sm_item)
    );

    tci_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (sm_vld),
        .o_ready  (sm_rdy),
        .i_item   (sm_item),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_height (height)
    );

    assign m_axis_tdata = TDATA_BITS'(height);

    // Requests in flight, kept for the checks below.
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    always_comb begin
        n_inflight = r_inflight;
        if (in_fire && !out_fire) begin
            n_inflight = r_inflight + INFL_BITS'(1);
        end else if (out_fire && !in_fire) begin
            n_inflight = r_inflight - INFL_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    // --------------------------------------------------------------- assertions
    // An empty output stage means every stage can move, so the input is ready.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the output stage is empty");

    // The pipeline never holds more requests than it has stages.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= INFL_BITS'(PIPE_DEPTH))
        else $error("more requests in flight than pipeline stages");

    // A result is only shown for a request that was accepted earlier.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_inflight != '0))
        else $error("result shown with no request in flight");

    // A full pipeline with a stalled output takes no new request.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == INFL_BITS'(PIPE_DEPTH)) && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken while the pipeline is full and stalled");

endmodule

### bench/tone_curve_checker.sv
// ----------------------------------------------------------------------------
// Tone curve checker
// Watches the register port and both sample streams of the tone curve block,
// keeps its own copy of the curve registers, predicts every mapped height and
// compares the results in order. Register reads are checked against the copy.
// ----------------------------------------------------------------------------
module tone_curve_checker import tci_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [ADDR_BITS-1:0]  i_paddr,
    input  logic [APB_BITS-1:0]   i_pwdata,
    input  logic [APB_BITS-1:0]   i_prdata,
    input  logic                  i_pready,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [TDATA_BITS-1:0] i_s_tdata,   // [15:0] sample
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [TDATA_BITS-1:0] i_m_tdata,   // [15:0] height
    output int                    o_pending,
    output int                    o_fail_count
);

    localparam logic [63:0] T_UNIT = 64'd1 << T_BITS;

    logic [CNT_BITS-1:0] count_reg;
    logic                smooth_reg;
    t_point              knots [MAX_POINTS];
    t_sample             heights_due [$];
    int                  mismatch_total;

    // Mapped height for one sample under the current register copy.
    function automatic t_sample curve_height(input t_sample s);
        int          n;
        int          seg;
        logic [63:0] lx;
        logic [63:0] rx;
        logic [63:0] ly;
        logic [63:0] ry;
        logic [63:0] t;
        n = int'(count_reg);
        if (n < 2) n = 2;
        if (n > MAX_POINTS) n = MAX_POINTS;
        seg = 0;
        while (seg < n && knots[seg].x <= s) seg++;
        if (seg == 0) return knots[0].y;
        if (seg >= n) return knots[n-1].y;
        lx = 64'(knots[seg-1].x);
        rx = 64'(knots[seg].x);
        ly = 64'(knots[seg-1].y);
        ry = 64'(knots[seg].y);
        t = ((64'(s) - lx) << T_BITS) / (rx - lx);
        if (smooth_reg) t = (t * t * (3 * T_UNIT - 2 * t)) >> (2 * T_BITS);
        return t_sample'((ly * (T_UNIT - t) + ry * t) >> T_BITS);
    endfunction

    function automatic logic [APB_BITS-1:0] register_value(input logic [REG_IDX_BITS-1:0] idx);
        if (idx == REG_POINT_COUNT) return APB_BITS'(count_reg);
        if (idx == REG_SMOOTH_MODE) return APB_BITS'(smooth_reg);
        return APB_BITS'(knots[int'(idx) - int'(REG_POINT_BASE)]);
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_total++;
        if (mismatch_total <= 10) $display("mismatch: %s", what);
    endtask

    always @(posedge i_clk) begin
        logic [REG_IDX_BITS-1:0] idx;
        t_sample                 want;
        idx = i_paddr[ADDR_BITS-1:2];
        if (!i_rst_n) begin
            count_reg  = CNT_BITS'(2);
            smooth_reg = 1'b0;
            foreach (knots[i]) knots[i] = '0;
            knots[1]   = '1;
            heights_due.delete();
            mismatch_total = 0;
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (idx == REG_POINT_COUNT) count_reg = i_pwdata[CNT_BITS-1:0];
                    else if (idx == REG_SMOOTH_MODE) smooth_reg = i_pwdata[0];
                    else knots[int'(idx) - int'(REG_POINT_BASE)] = i_pwdata;
                end else if (i_prdata !== register_value(idx)) begin
                    note_mismatch($sformatf("register %0d read expected %h, got %h",
                                            idx, register_value(idx), i_prdata));
                end
            end
            // A result can never stem from a request of the same cycle, so
            // the oldest expectation is taken before the new one is queued.
            if (i_m_tvalid && i_m_tready) begin
                if (heights_due.size() == 0) begin
                    note_mismatch($sformatf("height %h arrived with none expected",
                                            i_m_tdata[SAMPLE_BITS-1:0]));
                end else begin
                    want = heights_due.pop_front();
                    if (i_m_tdata[SAMPLE_BITS-1:0] !== want)
                        note_mismatch($sformatf("height expected %h, got %h",
                                                want, i_m_tdata[SAMPLE_BITS-1:0]));
                end
            end
            if (i_s_tvalid && i_s_tready)
                heights_due.push_back(curve_height(i_s_tdata[SAMPLE_BITS-1:0]));
        end
        o_pending    <= heights_due.size();
        o_fail_count <= mismatch_total;
    end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Tone curve interpolator testbench
// Programs a series of tone curves through the register port and streams
// directed and random height samples through the block, with random idling
// on both streams and long output stalls; a checker beside the block predicts
// and compares every mapped height.
// ----------------------------------------------------------------------------
module testbench;
    import tci_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 7;
    localparam int IDLE_PERCENT = 12;
    // Cycles without any handshake before the run is declared hung.
    localparam int QUIET_LIMIT  = 4000;
    // Settling time after the last expected height, well past the pipeline.
    localparam int DRAIN_CYCLES = PIPE_DEPTH + 8;
    // Length of the deliberate output stall, far beyond the pipeline depth.
    localparam int HOLD_CYCLES  = 90;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 115;

    typedef enum int {SHAPE_SPREAD, SHAPE_NARROW, SHAPE_SCRAMBLED} t_shape;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [ADDR_BITS-1:0]  paddr         = '0;
    logic [APB_BITS-1:0]   pwdata        = '0;
    logic [APB_BITS-1:0]   prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_BITS-1:0] s_axis_tdata  = '0;   // [15:0] sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_axis_tdata;         // [15:0] height

    int     pending;
    int     fail_count;
    int     results_taken = 0;
    // While set, neither stream idles.
    logic   steady = 1'b0;
    // Curve being programmed; the stimulus aims samples at its knees.
    t_point plan [MAX_POINTS];
    int     plan_n;

    // Per-phase settings: raw point_count written (0, 1 and 7 exercise the
    // clamping) and segment layout.
    int     count_plan [PHASES] = '{6, 2, 6, 3, 4, 5, 0, 7, 1, 6, 5, 6};
    t_shape shape_plan [PHASES] = '{SHAPE_SPREAD, SHAPE_SPREAD, SHAPE_SPREAD, SHAPE_NARROW,
                                    SHAPE_SPREAD, SHAPE_SPREAD, SHAPE_SPREAD, SHAPE_SPREAD,
                                    SHAPE_SCRAMBLED, SHAPE_SCRAMBLED, SHAPE_NARROW,
                                    SHAPE_SPREAD};

    always #HALF_PERIOD i_clk = ~i_clk;

    tone_curve_interpolator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tone_curve_checker height_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) results_taken <= results_taken + 1;
    end

    // The run is declared hung when no request, result or register access
    // completes before the quiet counter reaches its limit.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    // Result side. It normally stalls at random, but twice in the run it
    // holds tready low for a long stretch while the sample side keeps
    // offering requests, so the pipeline fills and the block stalls its input.
    initial begin : result_sink
        int hold_left;
        int next_hold;
        hold_left = 0;
        next_hold = 300;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && results_taken >= next_hold) begin
                hold_left = HOLD_CYCLES;
                next_hold = next_hold + 700;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // One register access, setup phase then access phase, after which the port
    // idles before the task returns. Entered and left at a falling edge.
    task automatic reg_access(input logic wr, input logic [REG_IDX_BITS-1:0] idx,
                              input logic [APB_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Writes every register from the current plan, then reads them all back.
    task automatic load_curve(input int count, input logic smooth);
        reg_access(1'b1, REG_POINT_COUNT, APB_BITS'(count));
        reg_access(1'b1, REG_SMOOTH_MODE, APB_BITS'(smooth));
        for (int i = 0; i < MAX_POINTS; i++)
            reg_access(1'b1, REG_IDX_BITS'(int'(REG_POINT_BASE) + i), APB_BITS'(plan[i]));
        for (int i = 0; i < REG_COUNT; i++)
            reg_access(1'b0, REG_IDX_BITS'(i), '0);
        plan_n = (count < 2) ? 2 : (count > MAX_POINTS ? MAX_POINTS : count);
    endtask

    // Offers one sample request, with random idle cycles ahead of it, and
    // returns at the falling edge after it was accepted. tvalid stays high
    // so that back-to-back requests leave no gap.
    task automatic send_sample(input t_sample s);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_BITS'(s);
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Ends a batch: the stream goes quiet, every expected height must come
    // back, and the pipeline is given time to settle before the registers
    // may change.
    task automatic drain_requests();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_sample random_y();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return t_sample'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // Builds a curve with n active points. Spread curves are well formed with
    // random knees; narrow ones pack the inner knees one or two apart;
    // scrambled ones have unsorted, often repeated x values that need not
    // start at zero or end at full scale. Inactive points hold random values.
    task automatic make_curve(input int n, input t_shape shape);
        t_point  tmp;
        t_sample base;
        logic    taken;
        for (int i = 0; i < MAX_POINTS; i++) begin
            plan[i].x = t_sample'($urandom_range(16'hFFFF));
            plan[i].y = random_y();
        end
        if (shape == SHAPE_SCRAMBLED) begin
            for (int i = 0; i < n; i++)
                if ($urandom_range(1)) plan[i].x = t_sample'($urandom_range(15) * 16'h1111);
        end else if (shape == SHAPE_NARROW) begin
            base = t_sample'($urandom_range(1, 60000));
            for (int i = 1; i < n - 1; i++) begin
                plan[i].x = base;
                base = base + t_sample'($urandom_range(1, 2));
            end
        end else begin
            for (int i = 1; i < n - 1; i++) begin
                do begin
                    plan[i].x = t_sample'($urandom_range(1, 16'hFFFE));
                    taken = 1'b0;
                    for (int j = 1; j < i; j++)
                        if (plan[j].x == plan[i].x) taken = 1'b1;
                end while (taken);
            end
            for (int i = 1; i < n - 1; i++)
                for (int j = i + 1; j < n - 1; j++)
                    if (plan[j].x < plan[i].x) begin
                        tmp     = plan[i];
                        plan[i] = plan[j];
                        plan[j] = tmp;
                    end
        end
        if (shape != SHAPE_SCRAMBLED) begin
            plan[0].x   = '0;
            plan[n-1].x = '1;
        end
    endtask

    // Mostly uniform samples, the rest on or beside an active knee or at
    // either end of the range.
    function automatic t_sample aim_sample();
        t_sample knee;
        knee = plan[$urandom_range(plan_n - 1)].x;
        case ($urandom_range(9))
            5:       return knee;
            6:       return knee - 1'b1;
            7:       return knee + 1'b1;
            8:       return $urandom_range(1) ? '1 : '0;
            default: return t_sample'($urandom_range(16'hFFFF));
        endcase
    endfunction

    initial begin : stimulus
        int n;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The reset curve is the identity line.
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'h8000);
        send_sample(16'hFFFE);
        send_sample(16'hFFFF);
        drain_requests();

        // Six points with a one-wide first segment, a full-scale y swing
        // and a one-wide last segment.
        plan[0] = '{x: 16'h0000, y: 16'hFFFF};
        plan[1] = '{x: 16'h0001, y: 16'h0000};
        plan[2] = '{x: 16'h4000, y: 16'h1234};
        plan[3] = '{x: 16'h8000, y: 16'hFFFF};
        plan[4] = '{x: 16'hFFFE, y: 16'h0000};
        plan[5] = '{x: 16'hFFFF, y: 16'h8001};
        load_curve(MAX_POINTS, 1'b0);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'h0002);
        send_sample(16'h3FFF);
        send_sample(16'h4000);
        send_sample(16'h9000);
        send_sample(16'hFFFD);
        send_sample(16'hFFFE);
        send_sample(16'hFFFF);
        drain_requests();

        // Same curve with the smoothstep blend.
        load_curve(MAX_POINTS, 1'b1);
        send_sample(16'h2000);
        send_sample(16'h6000);
        send_sample(16'hBFFF);
        send_sample(16'hC000);
        drain_requests();

        // Random curves, alternating linear and smooth blending.
        for (int ph = 0; ph < PHASES; ph++) begin
            n = count_plan[ph];
            n = (n < 2) ? 2 : (n > MAX_POINTS ? MAX_POINTS : n);
            make_curve(n, shape_plan[ph]);
            load_curve(count_plan[ph], logic'(ph % 2));
            steady = (ph == 4);
            repeat (PHASE_ITEMS) send_sample(aim_sample());
            drain_requests();
        end
        steady = 1'b0;

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
rtl/tci_pkg.sv
rtl/tci_seg.sv
rtl/tci_div.sv
rtl/tci_smooth.sv
rtl/tci_blend.sv
rtl/tone_curve_interpolator.sv
bench/tone_curve_checker.sv
bench/testbench.sv
